>>> rtl/core/tsp_pkg.sv
// Shared types and constants for the timestamp text parser.
// Holds the beat structs, field widths, character codes, status codes and month codes.
// No dependencies.
package tsp_pkg;

  localparam int YEAR_W = 14;
  localparam int FLD_W  = 7;

  // Characters taken by each group once it opens.
  localparam logic [2:0] YEAR_CHARS = 3'd4;
  localparam logic [2:0] FLD_CHARS  = 3'd2;

  localparam logic [2:0] GROUP_COUNT = 3'd6;
  localparam logic [3:0] MIN_LEN     = 4'd8;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // Month codes and field limits used by the range check.
  localparam logic [FLD_W-1:0] MON_JAN = 7'd1;
  localparam logic [FLD_W-1:0] MON_FEB = 7'd2;
  localparam logic [FLD_W-1:0] MON_APR = 7'd4;
  localparam logic [FLD_W-1:0] MON_JUN = 7'd6;
  localparam logic [FLD_W-1:0] MON_SEP = 7'd9;
  localparam logic [FLD_W-1:0] MON_NOV = 7'd11;
  localparam logic [FLD_W-1:0] MON_DEC = 7'd12;

  localparam logic [FLD_W-1:0] DAY_MIN      = 7'd1;
  localparam logic [FLD_W-1:0] DAY_MAX_LONG = 7'd31;
  localparam logic [FLD_W-1:0] DAY_MAX_30   = 7'd30;
  localparam logic [FLD_W-1:0] DAY_MAX_LEAP = 7'd29;
  localparam logic [FLD_W-1:0] DAY_MAX_FEB  = 7'd28;
  localparam logic [FLD_W-1:0] HOUR_MAX     = 7'd23;
  localparam logic [FLD_W-1:0] MINSEC_MAX   = 7'd59;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_beat_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year_value;
    logic [FLD_W-1:0]  month_value;
    logic [FLD_W-1:0]  day_value;
    logic [FLD_W-1:0]  hour_value;
    logic [FLD_W-1:0]  minute_value;
    logic [FLD_W-1:0]  second_value;
    logic [1:0]        status;
  } out_beat_t;

endpackage

>>> rtl/core/timestamp_text_parser.sv
// Timestamp text parser: one ASCII character per beat in, one parsed timestamp per string out.
// A last character goes through the input register, then the result register.
// Throughput: one character per cycle, save while a stalled output holds a last character.
// Reset (rst_n low, synchronous) clears the parse state and empties both registers.
// Depends on tsp_pkg and tsp_date_check.
module timestamp_text_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tsp_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output tsp_pkg::out_beat_t out_beat
);

  // Input register. A character that is not the last one never needs the result
  // register, so only a last character can be held here by a stalled output.
  logic              s1_valid_r;
  tsp_pkg::in_beat_t s1_beat_r;
  logic              s1_go;
  logic              take;
  logic              step;

  // Parse state.
  logic [3:0]                len_r,  len_upd;
  logic [2:0]                grp_r,  grp_upd;
  logic [2:0]                left_r, left_upd;
  logic                      live_r, live_upd;
  logic [tsp_pkg::YEAR_W-1:0] year_r, year_upd;
  // Decimal digits of the year group, ones digit at index 0, for the leap test.
  logic [3:0][3:0]           ydig_r, ydig_upd;
  // Month, day, hour, minute and second groups.
  logic [tsp_pkg::FLD_W-1:0] fld_r   [5];
  logic [tsp_pkg::FLD_W-1:0] fld_upd [5];

  // Result register.
  logic               out_valid_r;
  tsp_pkg::out_beat_t out_beat_r;

  logic       digit;
  logic [3:0] dv;
  logic [2:0] acc_idx;
  logic [2:0] open_idx;
  logic       cent_zero;
  logic       div4;
  logic       cent_div4;
  logic       leap;
  logic       date_ok;
  logic [1:0] status;

  assign s1_go    = !s1_beat_r.last_char || !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_go;
  assign take     = in_valid && !in_stall;
  assign step     = s1_valid_r && s1_go;

  assign digit    = (s1_beat_r.char_code >= tsp_pkg::CHAR_ZERO) &&
                    (s1_beat_r.char_code <= tsp_pkg::CHAR_NINE);
  assign dv       = digit ? 4'(s1_beat_r.char_code - tsp_pkg::CHAR_ZERO) : 4'd0;
  assign acc_idx  = grp_r - 3'd2;
  assign open_idx = grp_r - 3'd1;

  // Next parse state for the character in the input register. An open group
  // takes its full width of characters; its value accumulates only while every
  // character so far has been a digit. A digit outside a group opens the next one, up to six.
  always_comb begin
    len_upd  = (len_r < tsp_pkg::MIN_LEN) ? len_r + 4'd1 : len_r;
    grp_upd  = grp_r;
    left_upd = left_r;
    live_upd = live_r;
    year_upd = year_r;
    ydig_upd = ydig_r;
    fld_upd  = fld_r;
    if ((left_r != 3'd0) && (grp_r >= 3'd1) && (grp_r <= tsp_pkg::GROUP_COUNT)) begin
      if (live_r && digit) begin
        if (grp_r == 3'd1) begin
          year_upd = year_r * 14'd10 + {10'd0, dv};
          ydig_upd = {ydig_r[2:0], dv};
        end else begin
          fld_upd[acc_idx] = fld_r[acc_idx] * 7'd10 + {3'd0, dv};
        end
      end else begin
        live_upd = 1'b0;
      end
      left_upd = left_r - 3'd1;
    end else if (digit && (grp_r < tsp_pkg::GROUP_COUNT)) begin
      if (grp_r == 3'd0) begin
        year_upd = {10'd0, dv};
        ydig_upd = {12'd0, dv};
        left_upd = tsp_pkg::YEAR_CHARS - 3'd1;
      end else begin
        fld_upd[open_idx] = {3'd0, dv};
        left_upd = tsp_pkg::FLD_CHARS - 3'd1;
      end
      live_upd = 1'b1;
      grp_upd  = grp_r + 3'd1;
    end
  end

  // Leap year from the decimal digits: y mod 4 follows from the last two digits
  // and y/100 mod 4 from the first two, since 10 mod 4 is 2.
  assign cent_zero = (ydig_upd[1] == 4'd0) && (ydig_upd[0] == 4'd0);
  assign div4      = (2'({ydig_upd[1][0], 1'b0}) + ydig_upd[0][1:0]) == 2'd0;
  assign cent_div4 = (2'({ydig_upd[3][0], 1'b0}) + ydig_upd[2][1:0]) == 2'd0;
  assign leap      = cent_zero ? cent_div4 : div4;

  tsp_date_check u_date_check (
    .leap   (leap),
    .month  (fld_upd[0]),
    .day    (fld_upd[1]),
    .hour   (fld_upd[2]),
    .minute (fld_upd[3]),
    .second (fld_upd[4]),
    .ok     (date_ok)
  );

  // The too-short test wins over the range test.
  always_comb begin
    if (len_upd < tsp_pkg::MIN_LEN) begin
      status = tsp_pkg::ST_SHORT;
    end else if (!date_ok) begin
      status = tsp_pkg::ST_INVALID;
    end else begin
      status = tsp_pkg::ST_OK;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_beat_r <= in_beat;
    end
  end

  // Parse state. After the last character of a string everything starts over.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      grp_r  <= '0;
      left_r <= '0;
      live_r <= 1'b0;
      year_r <= '0;
      ydig_r <= '0;
      for (int i = 0; i < 5; i++) begin
        fld_r[i] <= '0;
      end
    end else if (step) begin
      if (s1_beat_r.last_char) begin
        len_r  <= '0;
        grp_r  <= '0;
        left_r <= '0;
        live_r <= 1'b0;
        year_r <= '0;
        ydig_r <= '0;
        for (int i = 0; i < 5; i++) begin
          fld_r[i] <= '0;
        end
      end else begin
        len_r  <= len_upd;
        grp_r  <= grp_upd;
        left_r <= left_upd;
        live_r <= live_upd;
        year_r <= year_upd;
        ydig_r <= ydig_upd;
        fld_r  <= fld_upd;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && s1_beat_r.last_char) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_beat_r.last_char) begin
      out_beat_r.year_value   <= year_upd;
      out_beat_r.month_value  <= fld_upd[0];
      out_beat_r.day_value    <= fld_upd[1];
      out_beat_r.hour_value   <= fld_upd[2];
      out_beat_r.minute_value <= fld_upd[3];
      out_beat_r.second_value <= fld_upd[4];
      out_beat_r.status       <= status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

>>> rtl/core/tsp_date_check.sv
// Range check of a parsed date and time: Gregorian month and day, hour, minute, second.
// Depends on tsp_pkg for widths, month codes and limits.
module tsp_date_check (
  input  logic                     leap,
  input  logic [tsp_pkg::FLD_W-1:0] month,
  input  logic [tsp_pkg::FLD_W-1:0] day,
  input  logic [tsp_pkg::FLD_W-1:0] hour,
  input  logic [tsp_pkg::FLD_W-1:0] minute,
  input  logic [tsp_pkg::FLD_W-1:0] second,
  output logic                     ok
);

  logic [tsp_pkg::FLD_W-1:0] day_max;

  always_comb begin
    case (month) inside
      tsp_pkg::MON_APR, tsp_pkg::MON_JUN, tsp_pkg::MON_SEP, tsp_pkg::MON_NOV: begin
        day_max = tsp_pkg::DAY_MAX_30;
      end
      tsp_pkg::MON_FEB: begin
        day_max = leap ? tsp_pkg::DAY_MAX_LEAP : tsp_pkg::DAY_MAX_FEB;
      end
      default: begin
        day_max = tsp_pkg::DAY_MAX_LONG;
      end
    endcase
  end

  assign ok = (month >= tsp_pkg::MON_JAN) && (month <= tsp_pkg::MON_DEC) &&
              (day >= tsp_pkg::DAY_MIN) && (day <= day_max) &&
              (hour <= tsp_pkg::HOUR_MAX) && (minute <= tsp_pkg::MINSEC_MAX) &&
              (second <= tsp_pkg::MINSEC_MAX);

endmodule

>>> bench/timestamp_text_parser_tb.sv
// Self-checking testbench for timestamp_text_parser: drives character codes one beat at a time
// and checks every parsed timestamp against a typed-in result or a predictor kept inside this file.
// Depends on tsp_pkg and on the timestamp_text_parser RTL.
`timescale 1ns / 1ps

module timestamp_text_parser_tb;

  // Cycles without a single accepted beat on either channel before the run is declared hung.
  // Idle and stall bursts stay well under this limit, so a healthy run never comes close.
  localparam int HANG_LIMIT = 200;
  // Random characters to send after the directed table.
  localparam int RANDOM_CHARS = 280;
  // Idling stops once this many random characters have gone out.
  localparam int QUIET_TAIL_START = 240;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  tsp_pkg::in_beat_t  in_beat   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  tsp_pkg::out_beat_t out_beat;

  timestamp_text_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Percentage chance of an idle burst before a beat (sender) or of a stall burst (receiver).
  // Zero gives stretches with no idling at all.
  int idle_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  // Parsed timestamps still owed by the block, oldest first.
  tsp_pkg::out_beat_t expected_stamps[$];

  // Parser state, mirroring what the block should hold between characters.
  logic [3:0]                 ts_len;
  logic [2:0]                 ts_grp;
  logic [2:0]                 ts_left;
  logic                       ts_live;
  logic [tsp_pkg::YEAR_W-1:0] ts_val [0:5];

  // Directed table: text of the string, whether the expected result is typed in, and that result.
  // In the text, '@' stands for the NUL character and '~' for 8'hFF.
  string              row_text[$];
  bit                 row_typed[$];
  tsp_pkg::out_beat_t row_want[$];

  // Scratch buffer for random strings.
  logic [7:0] stamp_text[$];

  function automatic void clear_stamp();
    ts_len  = '0;
    ts_grp  = '0;
    ts_left = '0;
    ts_live = 1'b0;
    for (int k = 0; k < 6; k++) ts_val[k] = '0;
  endfunction

  function automatic bit is_leap_year(int y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic bit date_valid(int y, int m, int d);
    if (m < tsp_pkg::MON_JAN || m > tsp_pkg::MON_DEC ||
        d < tsp_pkg::DAY_MIN || d > tsp_pkg::DAY_MAX_LONG) return 1'b0;
    if (m == tsp_pkg::MON_APR || m == tsp_pkg::MON_JUN ||
        m == tsp_pkg::MON_SEP || m == tsp_pkg::MON_NOV) return d <= tsp_pkg::DAY_MAX_30;
    if (m == tsp_pkg::MON_FEB)
      return is_leap_year(y) ? (d <= tsp_pkg::DAY_MAX_LEAP) : (d <= tsp_pkg::DAY_MAX_FEB);
    return 1'b1;
  endfunction

  // Advances the parser by one character. On the last character of a string it hands back
  // the parsed timestamp and clears the state, as the block does.
  function automatic void parse_char(input logic [7:0] c, input logic last,
                                     output bit done, output tsp_pkg::out_beat_t res);
    bit                         is_digit;
    logic [tsp_pkg::YEAR_W-1:0] digit_val;
    is_digit  = (c >= tsp_pkg::CHAR_ZERO) && (c <= tsp_pkg::CHAR_NINE);
    digit_val = is_digit ? tsp_pkg::YEAR_W'(c - tsp_pkg::CHAR_ZERO) : '0;
    done      = 1'b0;
    res       = '0;

    if (ts_len < tsp_pkg::MIN_LEN) ts_len = ts_len + 4'd1;

    if (ts_left != 0 && ts_grp >= 3'd1 && ts_grp <= tsp_pkg::GROUP_COUNT) begin
      // An open group swallows the character whatever it is; the value only grows while
      // the group has seen nothing but digits.
      if (ts_live && is_digit) begin
        ts_val[ts_grp - 3'd1] = tsp_pkg::YEAR_W'(ts_val[ts_grp - 3'd1] * 10 + digit_val);
      end else begin
        ts_live = 1'b0;
      end
      ts_left = ts_left - 3'd1;
    end else if (is_digit && ts_grp < tsp_pkg::GROUP_COUNT) begin
      // A digit between groups opens the next one; past the sixth group digits are skipped.
      ts_val[ts_grp] = digit_val;
      ts_left = (ts_grp == 3'd0) ? tsp_pkg::YEAR_CHARS - 3'd1 : tsp_pkg::FLD_CHARS - 3'd1;
      ts_live = 1'b1;
      ts_grp  = ts_grp + 3'd1;
    end

    if (!last) return;

    done = 1'b1;
    res.year_value   = ts_val[0];
    res.month_value  = ts_val[1][tsp_pkg::FLD_W-1:0];
    res.day_value    = ts_val[2][tsp_pkg::FLD_W-1:0];
    res.hour_value   = ts_val[3][tsp_pkg::FLD_W-1:0];
    res.minute_value = ts_val[4][tsp_pkg::FLD_W-1:0];
    res.second_value = ts_val[5][tsp_pkg::FLD_W-1:0];
    // The length test wins over the range test.
    if (ts_len < tsp_pkg::MIN_LEN) begin
      res.status = tsp_pkg::ST_SHORT;
    end else if (!date_valid(ts_val[0], ts_val[1], ts_val[2]) ||
                 ts_val[3] > tsp_pkg::HOUR_MAX ||
                 ts_val[4] > tsp_pkg::MINSEC_MAX || ts_val[5] > tsp_pkg::MINSEC_MAX) begin
      res.status = tsp_pkg::ST_INVALID;
    end else begin
      res.status = tsp_pkg::ST_OK;
    end
    clear_stamp();
  endfunction

  function automatic tsp_pkg::out_beat_t stamp(int y, int mo, int d, int h, int mi, int s,
                                               logic [1:0] st);
    tsp_pkg::out_beat_t b;
    b.year_value   = tsp_pkg::YEAR_W'(y);
    b.month_value  = tsp_pkg::FLD_W'(mo);
    b.day_value    = tsp_pkg::FLD_W'(d);
    b.hour_value   = tsp_pkg::FLD_W'(h);
    b.minute_value = tsp_pkg::FLD_W'(mi);
    b.second_value = tsp_pkg::FLD_W'(s);
    b.status       = st;
    return b;
  endfunction

  function automatic void add_row(string t, bit typed, tsp_pkg::out_beat_t want);
    row_text.push_back(t);
    row_typed.push_back(typed);
    row_want.push_back(want);
  endfunction

  function automatic logic [7:0] random_nondigit();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c >= tsp_pkg::CHAR_ZERO && c <= tsp_pkg::CHAR_NINE);
    return c;
  endfunction

  // Appends a value as exactly w decimal digits, most significant first.
  function automatic void add_digits(int val, int w);
    int div;
    div = 1;
    for (int k = 1; k < w; k++) div = div * 10;
    for (int k = 0; k < w; k++) begin
      stamp_text.push_back(tsp_pkg::CHAR_ZERO + 8'((val / div) % 10));
      div = div / 10;
    end
  endfunction

  // Sends one character and waits for the edge that takes it. The predictor runs at that
  // edge; on the last character the parsed timestamp, or the typed-in one, is queued.
  task automatic send_char(input logic [7:0] c, input logic last, input bit typed,
                           input tsp_pkg::out_beat_t want);
    bit                 done;
    tsp_pkg::out_beat_t res;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{char_code: c, last_char: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_char(c, last, done, res);
    if (done) expected_stamps.push_back(typed ? want : res);
  endtask

  task automatic send_buffer(output int count);
    count = stamp_text.size();
    for (int i = 0; i < stamp_text.size(); i++) begin
      send_char(stamp_text[i], i == stamp_text.size() - 1, 1'b0, '0);
    end
  endtask

  // Builds a mostly well-formed timestamp with random content, then sometimes damages it.
  function automatic void build_random_stamp();
    int         y, mo, d, h, mi, s;
    int         sep_mode;
    logic [7:0] sep;
    stamp_text.delete();
    case ($urandom_range(0, 3))
      0: y = $urandom_range(0, 9999);
      1: y = $urandom_range(0, 99) * 100;   // centuries exercise the 100 and 400 rules
      default: y = $urandom_range(1970, 2099);
    endcase
    mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    d  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
    if ($urandom_range(0, 5) == 0) begin
      mo = tsp_pkg::MON_FEB;
      d  = $urandom_range(28, 30);
    end
    h  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
    mi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
    s  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);

    sep_mode = $urandom_range(0, 2);
    if ($urandom_range(0, 7) == 0) stamp_text.push_back(random_nondigit());
    add_digits(y, 4);
    for (int g = 1; g < 6; g++) begin
      if (sep_mode != 0 && $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 3))
          0: sep = "-";
          1: sep = ":";
          2: sep = " ";
          default: sep = "T";
        endcase
        stamp_text.push_back(sep_mode == 2 ? random_nondigit() : sep);
      end
      case (g)
        1: add_digits(mo, 2);
        2: add_digits(d, 2);
        3: add_digits(h, 2);
        4: add_digits(mi, 2);
        default: add_digits(s, 2);
      endcase
    end

    if ($urandom_range(0, 7) == 0) begin
      int keep;
      keep = $urandom_range(1, stamp_text.size());
      while (stamp_text.size() > keep) void'(stamp_text.pop_back());
    end
    if ($urandom_range(0, 7) == 0) begin
      stamp_text[$urandom_range(0, stamp_text.size() - 1)] = 8'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        stamp_text.push_back($urandom_range(0, 1)
                             ? tsp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9))
                             : 8'($urandom_range(0, 255)));
      end
    end
  endfunction

  // Short strings of raw bytes, about half of them digits.
  function automatic void build_noise();
    stamp_text.delete();
    repeat ($urandom_range(1, 12)) begin
      stamp_text.push_back($urandom_range(0, 1)
                           ? tsp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9))
                           : 8'($urandom_range(0, 255)));
    end
  endfunction

  // Receiver side: stall in short random bursts while idling is enabled.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic report_field(string fname, int want, int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    mismatch_count++;
  endtask

  // Result monitor: every accepted result beat is matched against the oldest expectation.
  always @(posedge clk) begin
    tsp_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_stamps.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %p", $time, out_beat);
        mismatch_count++;
      end else begin
        want = expected_stamps.pop_front();
        if (out_beat.year_value !== want.year_value)
          report_field("year", want.year_value, out_beat.year_value);
        if (out_beat.month_value !== want.month_value)
          report_field("month", want.month_value, out_beat.month_value);
        if (out_beat.day_value !== want.day_value)
          report_field("day", want.day_value, out_beat.day_value);
        if (out_beat.hour_value !== want.hour_value)
          report_field("hour", want.hour_value, out_beat.hour_value);
        if (out_beat.minute_value !== want.minute_value)
          report_field("minute", want.minute_value, out_beat.minute_value);
        if (out_beat.second_value !== want.second_value)
          report_field("second", want.second_value, out_beat.second_value);
        if (out_beat.status !== want.status)
          report_field("status", want.status, out_beat.status);
      end
    end
  end

  // Hang detector: counts cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= HANG_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, HANG_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    string      t;
    logic [7:0] c;
    int         sent;
    int         n;

    clear_stamp();

    // Directed strings. Results that can be read off directly are typed in; the rest come
    // from the predictor.
    add_row("9", 1'b1, stamp(9, 0, 0, 0, 0, 0, tsp_pkg::ST_SHORT));
    // Too short takes priority even though the day group reads zero, which is out of range.
    add_row("99999", 1'b1, stamp(9999, 9, 0, 0, 0, 0, tsp_pkg::ST_SHORT));
    add_row("2024010", 1'b1, stamp(2024, 1, 0, 0, 0, 0, tsp_pkg::ST_SHORT));
    add_row("20240229235959", 1'b1, stamp(2024, 2, 29, 23, 59, 59, tsp_pkg::ST_OK));
    add_row("19000229000000", 1'b1, stamp(1900, 2, 29, 0, 0, 0, tsp_pkg::ST_INVALID));
    add_row("20000229000000", 1'b0, '0);
    // Exactly eight characters, missing time groups read as zero.
    add_row("21000229", 1'b0, '0);
    add_row("2023-04-31T12:00:00", 1'b0, '0);
    add_row("2023-13-01 24:60:60", 1'b1,
            stamp(2023, 13, 1, 24, 60, 60, tsp_pkg::ST_INVALID));
    add_row("2023-00-00", 1'b1, stamp(2023, 0, 0, 0, 0, 0, tsp_pkg::ST_INVALID));
    add_row("2023-11-31 23:59:60", 1'b0, '0);
    add_row("00000101000000", 1'b1, stamp(0, 1, 1, 0, 0, 0, tsp_pkg::ST_OK));
    add_row("99991231235959", 1'b1, stamp(9999, 12, 31, 23, 59, 59, tsp_pkg::ST_OK));
    // Character code extremes and the neighbors of '0' and '9' as separators.
    add_row("@~2024/06/15:12:30:45~@", 1'b0, '0);
    // A non-digit inside the year group freezes its value but the group still runs its width.
    add_row("20x40101120000", 1'b0, '0);
    // Groups cut short by separators.
    add_row("1 2 3 4 5 6 7 8", 1'b0, '0);
    // Digits after the sixth group are skipped.
    add_row("20240101000000777", 1'b0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < row_text.size(); r++) begin
      t = row_text[r];
      for (int i = 0; i < t.len(); i++) begin
        c = t[i];
        if (c == "@") c = 8'h00;
        else if (c == "~") c = 8'hFF;
        send_char(c, i == t.len() - 1, row_typed[r], row_want[r]);
      end
    end

    // Random part: mostly timestamps with random content, the rest raw noise. The idling
    // rate changes from string to string and drops to zero for the tail of the run.
    sent = 0;
    while (sent < RANDOM_CHARS) begin
      if (sent >= QUIET_TAIL_START) begin
        idle_pct = 0;
      end else if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      if ($urandom_range(0, 4) != 0) build_random_stamp();
      else build_noise();
      send_buffer(n);
      sent += n;
    end
    in_valid <= 1'b0;

    // Drain: the hang detector bounds this wait, which ends once every expected result is taken.
    while (expected_stamps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
